// ===== rtl/multidim_histogram_binner_top_macros.svh =====
// ----------------------------------------------------------------------------
// multidim_histogram_binner_top_macros
// assertion macros shared by the histogram binner rtl
// ----------------------------------------------------------------------------
`ifndef MULTIDIM_HISTOGRAM_BINNER_TOP_MACROS_SVH
`define MULTIDIM_HISTOGRAM_BINNER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// check prop at every rising edge of clk, off while rst_n is low
`define MHB_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check prop at every rising edge of clk, also during reset
`define MHB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MHB_ASSERT(lbl, clk, rst_n, prop, msg)
`define MHB_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/mhb_pkg.sv =====
// ----------------------------------------------------------------------------
// mhb_pkg
// types and constants of the multidimensional histogram binner
// ----------------------------------------------------------------------------
`default_nettype none

package mhb_pkg;

	localparam int unsigned HIST_DEPTH_DEF = 65536;
	localparam int unsigned SUM_WIDTH_DEF  = 48;

	localparam int unsigned MAX_DIMS   = 4;
	localparam int unsigned NUM_COORDS = 4;
	localparam int unsigned DIM_LIMIT  = (MAX_DIMS < NUM_COORDS) ? MAX_DIMS : NUM_COORDS;

	localparam int unsigned CFG_AW  = 5;
	localparam int unsigned CFG_DW  = 32;
	localparam int unsigned BINS_W  = 17;
	localparam int unsigned IX_W    = 15;
	localparam int unsigned IN_DW   = 208;
	localparam int unsigned OUT_DW  = 112;
	localparam int unsigned OUT_SUM = 48;

	typedef enum logic [1:0] {
		CMD_ADD        = 2'd0,
		CMD_READ       = 2'd1,
		CMD_READ_CLEAR = 2'd2,
		CMD_NONE       = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		REG_DIM_COUNT  = 3'd0,
		REG_BINS_DIM0  = 3'd1,
		REG_BINS_DIM1  = 3'd2,
		REG_BINS_DIM2  = 3'd3,
		REG_BINS_DIM3  = 3'd4,
		REG_CHUNK_LOW  = 3'd5,
		REG_CHUNK_HIGH = 3'd6,
		REG_UNUSED     = 3'd7
	} reg_idx_t;

	localparam logic [2:0]        DIM_COUNT_RST  = 3'd1;
	localparam logic [BINS_W-1:0] BINS_DIM0_RST  = 17'd256;
	localparam logic [BINS_W-1:0] BINS_DIMX_RST  = 17'd1;
	localparam logic [BINS_W-1:0] CHUNK_LOW_RST  = 17'd0;
	localparam logic [BINS_W-1:0] CHUNK_HIGH_RST = 17'd256;

endpackage

`default_nettype wire

// ===== rtl/multidim_histogram_binner_top.sv =====
// ----------------------------------------------------------------------------
// multidim_histogram_binner_top
// floors up to four coordinates to bins and accumulates signal and error
// ----------------------------------------------------------------------------
// After reset the block clears its HIST_DEPTH bins, one a cycle; no item is
// taken meanwhile, configuration writes are. Items are then worked one at a
// time: an add steps once per dimension through the index multiplier, then
// read-modify-writes the memory, then hands its result to the output
// register once that is free; a read skips the index steps, an add rejected
// by the bounds checks goes straight to the hand-over. A result waiting in
// the output register does not block the next item from being taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "multidim_histogram_binner_top_macros.svh"

module multidim_histogram_binner_top
	import mhb_pkg::*;
#(
	parameter int unsigned HIST_DEPTH = HIST_DEPTH_DEF,
	parameter int unsigned SUM_WIDTH  = SUM_WIDTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	// coord_0, coord_1, coord_2, coord_3, event_signal, event_error_sq, read_index
	input  wire logic [IN_DW-1:0]  s_tdata,
	// command
	input  wire logic [1:0]        s_tuser,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	// bin_index, signal_sum, error_sum
	output logic [OUT_DW-1:0]      m_tdata,
	// accepted, saturated
	output logic [1:0]             m_tuser,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [CFG_AW-1:0] paddr,
	input  wire logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0]      prdata,
	output logic                   pready
);

	localparam int unsigned AW = $clog2(HIST_DEPTH);
	localparam int unsigned MW = $clog2(HIST_DEPTH + 1);
	localparam int unsigned PW = MW + BINS_W + 1;
	localparam int unsigned SW = SUM_WIDTH;

	typedef enum logic [4:0] {
		ST_CLEAR  = 5'b00001,
		ST_IDLE   = 5'b00010,
		ST_INDEX  = 5'b00100,
		ST_MOD    = 5'b01000,
		ST_RESULT = 5'b10000
	} state_t;

	state_t state_q;

	// configuration
	logic [2:0]        dim_count_q;
	logic [BINS_W-1:0] bins_q [NUM_COORDS];
	logic [BINS_W-1:0] chunk_low_q;
	logic [BINS_W-1:0] chunk_high_q;
	logic              cfg_we;
	reg_idx_t          cfg_idx;

	assign pready  = 1'b1;
	assign cfg_we  = psel & penable & pwrite & pready;
	assign cfg_idx = reg_idx_t'(paddr[CFG_AW-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_count_q  <= DIM_COUNT_RST;
			bins_q[0]    <= BINS_DIM0_RST;
			bins_q[1]    <= BINS_DIMX_RST;
			bins_q[2]    <= BINS_DIMX_RST;
			bins_q[3]    <= BINS_DIMX_RST;
			chunk_low_q  <= CHUNK_LOW_RST;
			chunk_high_q <= CHUNK_HIGH_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_DIM_COUNT:  dim_count_q  <= pwdata[2:0];
				REG_BINS_DIM0:  bins_q[0]    <= pwdata[BINS_W-1:0];
				REG_BINS_DIM1:  bins_q[1]    <= pwdata[BINS_W-1:0];
				REG_BINS_DIM2:  bins_q[2]    <= pwdata[BINS_W-1:0];
				REG_BINS_DIM3:  bins_q[3]    <= pwdata[BINS_W-1:0];
				REG_CHUNK_LOW:  chunk_low_q  <= pwdata[BINS_W-1:0];
				REG_CHUNK_HIGH: chunk_high_q <= pwdata[BINS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_DIM_COUNT:  prdata = CFG_DW'(dim_count_q);
			REG_BINS_DIM0:  prdata = CFG_DW'(bins_q[0]);
			REG_BINS_DIM1:  prdata = CFG_DW'(bins_q[1]);
			REG_BINS_DIM2:  prdata = CFG_DW'(bins_q[2]);
			REG_BINS_DIM3:  prdata = CFG_DW'(bins_q[3]);
			REG_CHUNK_LOW:  prdata = CFG_DW'(chunk_low_q);
			REG_CHUNK_HIGH: prdata = CFG_DW'(chunk_high_q);
			default:        prdata = '0;
		endcase
	end

	// input fields
	cmd_t               in_cmd;
	logic signed [31:0] in_signal;
	logic [31:0]        in_error;
	logic [15:0]        in_ridx;
	logic [IX_W-1:0]    in_ix [NUM_COORDS];
	logic [2:0]         dims_c;
	logic               reject_c;
	logic               ridx_oob_c;
	logic               in_xfer;

	assign in_cmd    = cmd_t'(s_tuser);
	assign in_signal = s_tdata[159:128];
	assign in_error  = s_tdata[191:160];
	assign in_ridx   = s_tdata[207:192];
	assign in_xfer   = s_tvalid & s_tready;
	assign s_tready  = (state_q == ST_IDLE);

	always_comb begin
		priority if (dim_count_q == 3'd0)
			dims_c = 3'd1;
		else if (dim_count_q > 3'(DIM_LIMIT))
			dims_c = 3'(DIM_LIMIT);
		else
			dims_c = dim_count_q;
	end

	// bounds checks of every dimension in use and the window on dimension zero, in parallel
	always_comb begin
		reject_c = 1'b0;
		for (int d = 0; d < NUM_COORDS; d++) begin
			in_ix[d] = s_tdata[32*d+16 +: IX_W];
			if (3'(d) < dims_c) begin
				if (s_tdata[32*d+31] || ({2'b00, in_ix[d]} >= bins_q[d]))
					reject_c = 1'b1;
			end
		end
		if (({2'b00, in_ix[0]} < chunk_low_q) || ({2'b00, in_ix[0]} >= chunk_high_q))
			reject_c = 1'b1;
	end

	assign ridx_oob_c = (PW'(in_ridx) >= PW'(HIST_DEPTH));

	// working registers
	cmd_t               cmd_q;
	logic [IX_W-1:0]    ix_q [NUM_COORDS];
	logic signed [31:0] sig_q;
	logic [31:0]        err_q;
	logic [1:0]         d_q;
	logic [1:0]         dlast_q;
	logic [AW-1:0]      lin_q;
	logic [MW-1:0]      mult_q;
	logic [AW-1:0]      addr_q;
	logic [AW-1:0]      clr_q;

	// index step: lin += ix * mult, mult *= bins
	logic [PW-1:0] prod_c;
	logic [PW-1:0] lin_nx_c;
	logic [PW-1:0] mprod_c;
	logic [MW-1:0] mult_nx_c;
	logic          lin_oob_c;

	assign prod_c    = PW'(ix_q[d_q]) * PW'(mult_q);
	assign lin_nx_c  = PW'(lin_q) + prod_c;
	assign lin_oob_c = (lin_nx_c >= PW'(HIST_DEPTH));
	assign mprod_c   = PW'(mult_q) * PW'(bins_q[d_q]);
	assign mult_nx_c = (mprod_c > PW'(HIST_DEPTH)) ? MW'(HIST_DEPTH) : mprod_c[MW-1:0];

	// histogram memory, error in the upper half, signal in the lower
	logic [2*SW-1:0] hist_mem_q [HIST_DEPTH];
	logic [2*SW-1:0] rd_data_q;
	logic            rd_en;
	logic [AW-1:0]   rd_addr;
	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	logic [2*SW-1:0] wr_data;

	always_ff @(posedge clk) begin
		if (wr_en)
			hist_mem_q[wr_addr] <= wr_data;
		if (rd_en)
			rd_data_q <= hist_mem_q[rd_addr];
	end

	// saturating accumulation
	logic signed [SW-1:0] old_sig;
	logic [SW-1:0]        old_err;
	logic signed [SW:0]   sig_sum_c;
	logic [SW:0]          err_sum_c;
	logic signed [SW-1:0] new_sig_c;
	logic [SW-1:0]        new_err_c;
	logic                 sat_c;

	assign old_sig   = rd_data_q[SW-1:0];
	assign old_err   = rd_data_q[2*SW-1:SW];
	assign sig_sum_c = (SW+1)'(old_sig) + (SW+1)'(sig_q);
	assign err_sum_c = {1'b0, old_err} + (SW+1)'(err_q);

	always_comb begin
		if (sig_sum_c[SW] != sig_sum_c[SW-1])
			new_sig_c = sig_sum_c[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
		else
			new_sig_c = sig_sum_c[SW-1:0];
		new_err_c = err_sum_c[SW] ? {SW{1'b1}} : err_sum_c[SW-1:0];
		sat_c     = (sig_sum_c[SW] != sig_sum_c[SW-1]) | err_sum_c[SW];
	end

	// memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = AW'(in_ridx);
		wr_en   = 1'b0;
		wr_addr = addr_q;
		wr_data = {new_err_c, new_sig_c};
		unique case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
			end
			ST_IDLE: begin
				rd_en = in_xfer & (in_cmd == CMD_READ || in_cmd == CMD_READ_CLEAR) & !ridx_oob_c;
			end
			ST_INDEX: begin
				rd_en   = (d_q == dlast_q) & !lin_oob_c;
				rd_addr = lin_nx_c[AW-1:0];
			end
			ST_MOD: begin
				wr_en = (cmd_q == CMD_ADD) || (cmd_q == CMD_READ_CLEAR);
				if (cmd_q == CMD_READ_CLEAR)
					wr_data = '0;
			end
			ST_RESULT: ;
			default: ;
		endcase
	end

	// result fields, widened or cut to the port widths
	logic signed [63:0] new_sig_w;
	logic signed [63:0] old_sig_w;
	logic [63:0]        new_err_w;
	logic [63:0]        old_err_w;

	assign new_sig_w = 64'(new_sig_c);
	assign old_sig_w = 64'(old_sig);
	assign new_err_w = 64'(new_err_c);
	assign old_err_w = 64'(old_err);

	logic               res_acc_q;
	logic [15:0]        res_idx_q;
	logic [OUT_SUM-1:0] res_sig_q;
	logic [OUT_SUM-1:0] res_err_q;
	logic               res_sat_q;
	logic               out_free;

	assign out_free = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(HIST_DEPTH - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_xfer) begin
						unique case (in_cmd)
							CMD_ADD:
								state_q <= reject_c ? ST_RESULT : ST_INDEX;
							CMD_READ, CMD_READ_CLEAR:
								state_q <= ridx_oob_c ? ST_RESULT : ST_MOD;
							default:
								state_q <= ST_RESULT;
						endcase
					end
				end
				ST_INDEX: begin
					if (lin_oob_c)
						state_q <= ST_RESULT;
					else if (d_q == dlast_q)
						state_q <= ST_MOD;
				end
				ST_MOD:    state_q <= ST_RESULT;
				ST_RESULT: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				cmd_q   <= in_cmd;
				ix_q    <= in_ix;
				sig_q   <= in_signal;
				err_q   <= in_error;
				d_q     <= '0;
				dlast_q <= 2'(dims_c - 3'd1);
				lin_q   <= '0;
				mult_q  <= MW'(1);
				addr_q  <= AW'(in_ridx);
				res_acc_q <= 1'b0;
				res_idx_q <= ((in_cmd == CMD_READ || in_cmd == CMD_READ_CLEAR)) ? in_ridx : 16'd0;
				res_sig_q <= '0;
				res_err_q <= '0;
				res_sat_q <= 1'b0;
			end
			ST_INDEX: begin
				d_q    <= d_q + 2'd1;
				lin_q  <= lin_nx_c[AW-1:0];
				mult_q <= mult_nx_c;
				addr_q <= lin_nx_c[AW-1:0];
			end
			ST_MOD: begin
				res_acc_q <= 1'b1;
				res_idx_q <= 16'(addr_q);
				if (cmd_q == CMD_ADD) begin
					res_sig_q <= new_sig_w[OUT_SUM-1:0];
					res_err_q <= new_err_w[OUT_SUM-1:0];
					res_sat_q <= sat_c;
				end else begin
					res_sig_q <= old_sig_w[OUT_SUM-1:0];
					res_err_q <= old_err_w[OUT_SUM-1:0];
					res_sat_q <= 1'b0;
				end
			end
			ST_CLEAR, ST_RESULT: ;
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (state_q == ST_RESULT && out_free) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESULT && out_free) begin
			m_tdata <= {res_err_q, res_sig_q, res_idx_q};
			m_tuser <= {res_sat_q, res_acc_q};
		end
	end

	`MHB_ASSERT(a_take_leaves_idle, clk, arst_n, in_xfer |=> state_q != ST_IDLE, "item taken but block stayed idle")
	`MHB_ASSERT(a_out_from_result, clk, arst_n, $rose(m_tvalid) |-> $past(state_q == ST_RESULT), "result shown without a result cycle")
	`MHB_ASSERT(a_sat_only_accepted, clk, arst_n, m_tvalid && m_tuser[1] |-> m_tuser[0], "saturation flagged on a rejected item")
	`MHB_ASSERT(a_reject_zero_sums, clk, arst_n, m_tvalid && !m_tuser[0] |-> m_tdata[OUT_DW-1:16] == '0, "rejected item carries sums")
	`MHB_ASSERT(a_no_take_clearing, clk, arst_n, state_q == ST_CLEAR |-> !s_tready && wr_en, "item taken or no write while clearing")

endmodule

`default_nettype wire

// ===== tb/multidim_histogram_binner_top_tb.sv =====
// ----------------------------------------------------------------------------
// multidim_histogram_binner_top_tb
// self-checking bench for the histogram binner: a queue of commands feeds a
// bursty stream driver, every input transfer runs through a local bin
// predictor and the output stream is compared in order; several register
// settings are visited, with degenerate windows, zero bin counts and index
// overflow past the memory
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multidim_histogram_binner_top_tb
	import mhb_pkg::*;
();

	localparam int unsigned      SLOTS       = HIST_DEPTH_DEF;
	localparam int unsigned      SETTLE      = 16;
	localparam longint           SIG_MAX     = (64'sd1 <<< 47) - 1;
	localparam longint           SIG_MIN     = -SIG_MAX - 1;
	localparam longint unsigned  ERR_MAX     = (64'd1 << 48) - 1;

	typedef struct packed {
		cmd_t             cmd;
		logic [3:0][31:0] coord;
		logic [31:0]      weight;
		logic [31:0]      err_sq;
		logic [15:0]      rd_index;
	} hist_cmd_t;

	typedef struct packed {
		logic        accepted;
		logic [15:0] bin_index;
		logic [47:0] sig_sum;
		logic [47:0] err_sum;
		logic        saturated;
	} bin_result_t;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [IN_DW-1:0]    s_tdata  = '0;
	logic [1:0]          s_tuser  = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OUT_DW-1:0]   m_tdata;
	logic [1:0]          m_tuser;
	logic                psel     = 1'b0;
	logic                penable  = 1'b0;
	logic                pwrite   = 1'b0;
	logic [CFG_AW-1:0]   paddr    = '0;
	logic [CFG_DW-1:0]   pwdata   = '0;
	logic [CFG_DW-1:0]   prdata;
	logic                pready;

	// local copy of the histogram and the registers
	logic signed [47:0]  sig_mem [SLOTS];
	logic [47:0]         err_mem [SLOTS];
	logic [2:0]          cfg_dims     = DIM_COUNT_RST;
	logic [BINS_W-1:0]   cfg_bins [4] = '{BINS_DIM0_RST, BINS_DIMX_RST, BINS_DIMX_RST,
		BINS_DIMX_RST};
	logic [BINS_W-1:0]   cfg_chunk_lo = CHUNK_LOW_RST;
	logic [BINS_W-1:0]   cfg_chunk_hi = CHUNK_HIGH_RST;

	hist_cmd_t           queued_cmds[$];
	bin_result_t         pending_outcomes[$];
	hist_cmd_t           on_bus;
	bin_result_t         got_res;
	bin_result_t         want_res;
	int unsigned         bad_outcomes = 0;
	int unsigned         burst_left   = 0;
	int unsigned         gap_left     = 0;
	int unsigned         gap_max      = 0;
	int unsigned         ready_mode   = 0;
	int unsigned         stall_count  = 0;

	multidim_histogram_binner_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #10 clk = ~clk;

	function automatic int unsigned eff_dims();
		if (cfg_dims == 0)
			return 1;
		if (cfg_dims > MAX_DIMS)
			return MAX_DIMS;
		return cfg_dims;
	endfunction

	function automatic bin_result_t bin_outcome(input hist_cmd_t c);
		bin_result_t     r;
		longint unsigned lin, mult, ix;
		longint          acc_s;
		longint unsigned acc_e;
		int unsigned     d;
		r = '0;
		case (c.cmd)
			CMD_ADD: begin
				lin  = 0;
				mult = 1;
				for (d = 0; d < eff_dims(); d++) begin
					if (c.coord[d][31])
						return r;
					ix = c.coord[d][30:16];
					if (ix >= cfg_bins[d])
						return r;
					if (d == 0 && (ix < cfg_chunk_lo || ix >= cfg_chunk_hi))
						return r;
					lin += ix * mult;
					if (lin >= SLOTS)
						return r;
					mult *= cfg_bins[d];
					if (mult > SLOTS)
						mult = SLOTS;
				end
				acc_s = longint'(sig_mem[lin]) + longint'($signed(c.weight));
				acc_e = longint'(err_mem[lin]) + longint'(c.err_sq);
				if (acc_s > SIG_MAX) begin
					acc_s = SIG_MAX;
					r.saturated = 1'b1;
				end else if (acc_s < SIG_MIN) begin
					acc_s = SIG_MIN;
					r.saturated = 1'b1;
				end
				if (acc_e > ERR_MAX) begin
					acc_e = ERR_MAX;
					r.saturated = 1'b1;
				end
				sig_mem[lin] = acc_s[47:0];
				err_mem[lin] = acc_e[47:0];
				r.accepted  = 1'b1;
				r.bin_index = lin[15:0];
				r.sig_sum   = acc_s[47:0];
				r.err_sum   = acc_e[47:0];
			end
			CMD_READ, CMD_READ_CLEAR: begin
				r.accepted  = 1'b1;
				r.bin_index = c.rd_index;
				r.sig_sum   = sig_mem[c.rd_index];
				r.err_sum   = err_mem[c.rd_index];
				if (c.cmd == CMD_READ_CLEAR) begin
					sig_mem[c.rd_index] = '0;
					err_mem[c.rd_index] = '0;
				end
			end
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic hist_cmd_t add_at(input logic [31:0] c0, input logic [31:0] w,
		input logic [31:0] e);
		hist_cmd_t c;
		c.cmd      = CMD_ADD;
		c.coord    = {$urandom, $urandom, $urandom, c0};
		c.weight   = w;
		c.err_sq   = e;
		c.rd_index = 16'($urandom);
		return c;
	endfunction

	function automatic hist_cmd_t read_at(input cmd_t k, input logic [15:0] idx);
		hist_cmd_t c;
		c          = add_at($urandom, $urandom, $urandom);
		c.cmd      = k;
		c.rd_index = idx;
		return c;
	endfunction

	// coordinate whose floor lands inside the accepted range of dimension d, or a random one if that range is empty
	function automatic logic [31:0] coord_in_range(input int d);
		int unsigned lo, hi;
		lo = 0;
		hi = cfg_bins[d];
		if (d == 0) begin
			lo = cfg_chunk_lo;
			if (cfg_chunk_hi < hi)
				hi = cfg_chunk_hi;
		end
		if (hi > 32768)
			hi = 32768;
		if (hi <= lo)
			return $urandom;
		return {1'b0, 15'($urandom_range(hi - 1, lo)), 16'($urandom)};
	endfunction

	function automatic hist_cmd_t random_cmd();
		hist_cmd_t       c;
		int unsigned     roll;
		longint unsigned span;
		int              d;
		span = 1;
		for (d = 0; d < eff_dims(); d++) begin
			span *= cfg_bins[d];
			if (span > SLOTS)
				span = SLOTS;
		end
		if (span == 0)
			span = 1;
		c    = add_at($urandom, $urandom, $urandom);
		roll = $urandom_range(0, 99);
		if (roll < 60) begin
			if (roll < 52) begin
				for (d = 0; d < 4; d++)
					c.coord[d] = coord_in_range(d);
				if (roll < 4)
					c.coord[$urandom_range(0, 3)][31] = 1'b1;
			end
		end else if (roll < 95) begin
			c.cmd = (roll < 78) ? CMD_READ : CMD_READ_CLEAR;
			if (roll % 4 != 0)
				c.rd_index = 16'($urandom_range(span - 1, 0));
		end else begin
			c.cmd = CMD_NONE;
		end
		return c;
	endfunction

	task automatic wait_idle();
		while (queued_cmds.size() != 0 || s_tvalid || pending_outcomes.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic apb_access(input reg_idx_t idx, input logic [31:0] wval,
		input logic wr, output logic [31:0] rval);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= wval;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rval = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_config(input int unsigned dims, input int unsigned b0,
		input int unsigned b1, input int unsigned b2, input int unsigned b3,
		input int unsigned lo, input int unsigned hi);
		logic [31:0] vals [7];
		logic [31:0] rd;
		vals = '{dims & 32'h7, b0 & 32'h1FFFF, b1 & 32'h1FFFF, b2 & 32'h1FFFF,
			b3 & 32'h1FFFF, lo & 32'h1FFFF, hi & 32'h1FFFF};
		for (int i = 0; i < 7; i++) begin
			apb_access(reg_idx_t'(i), vals[i], 1'b1, rd);
			apb_access(reg_idx_t'(i), '0, 1'b0, rd);
			if (rd !== vals[i]) begin
				bad_outcomes++;
				if (bad_outcomes <= 10)
					$display("register %0d readback: expected %0h actual %0h",
						i, vals[i], rd);
			end
		end
		cfg_dims     = vals[0][2:0];
		cfg_bins[0]  = vals[1][16:0];
		cfg_bins[1]  = vals[2][16:0];
		cfg_bins[2]  = vals[3][16:0];
		cfg_bins[3]  = vals[4][16:0];
		cfg_chunk_lo = vals[5][16:0];
		cfg_chunk_hi = vals[6][16:0];
	endtask

	task automatic run_random(input int unsigned n, input int unsigned gaps,
		input int unsigned rmode);
		gap_max    = gaps;
		ready_mode = rmode;
		repeat (n) queued_cmds.push_back(random_cmd());
		wait_idle();
	endtask

	// input side, bursts with gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid   <= 1'b0;
			s_tdata    <= '0;
			s_tuser    <= '0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			if (s_tvalid && s_tready)
				pending_outcomes.push_back(bin_outcome(on_bus));
			if (!s_tvalid || s_tready) begin
				if (gap_left != 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (queued_cmds.size() != 0) begin
					on_bus = queued_cmds.pop_front();
					s_tdata  <= {on_bus.rd_index, on_bus.err_sq, on_bus.weight, on_bus.coord};
					s_tuser  <= on_bus.cmd;
					s_tvalid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(12, 1);
						gap_left   = $urandom_range(gap_max, 0);
					end else begin
						burst_left--;
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// output side, stall pattern and compare
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready    <= 1'b0;
			stall_count = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_res = {m_tuser[0], m_tdata[15:0], m_tdata[63:16], m_tdata[111:64],
					m_tuser[1]};
				if (pending_outcomes.size() == 0) begin
					bad_outcomes++;
					if (bad_outcomes <= 10)
						$display("unexpected transfer at %0t: bin %0d", $realtime,
							got_res.bin_index);
				end else begin
					want_res = pending_outcomes.pop_front();
					if (got_res !== want_res) begin
						bad_outcomes++;
						if (bad_outcomes <= 10)
							$display({"mismatch at %0t (exp/act): acc %0b/%0b bin %0d/%0d",
								" sig %0d/%0d err %0d/%0d sat %0b/%0b"}, $realtime,
								want_res.accepted, got_res.accepted,
								want_res.bin_index, got_res.bin_index,
								$signed(want_res.sig_sum), $signed(got_res.sig_sum),
								want_res.err_sum, got_res.err_sum,
								want_res.saturated, got_res.saturated);
					end
				end
			end
			stall_count++;
			case (ready_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(9, 0) < 7);
				default: m_tready <= (stall_count % 7 != 3) && (stall_count % 29 >= 4);
			endcase
		end
	end

	initial begin
		#60_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			sig_mem[i] = '0;
			err_mem[i] = '0;
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset values: edges of dimension zero, back-to-back sums on one bin
		gap_max    = 0;
		ready_mode = 0;
		queued_cmds.push_back(add_at(32'h0000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
		queued_cmds.push_back(add_at(32'h00FF_FFFF, 32'h8000_0000, 32'h0000_0000));
		queued_cmds.push_back(add_at(32'h0100_0000, $urandom, $urandom));
		queued_cmds.push_back(add_at(32'h8000_0000, $urandom, $urandom));
		queued_cmds.push_back(add_at(32'hFFFF_FFFF, $urandom, $urandom));
		queued_cmds.push_back(add_at(32'h7FFF_FFFF, $urandom, $urandom));
		queued_cmds.push_back(add_at(32'h0005_8000, 32'h0000_0003, 32'h0001_0000));
		queued_cmds.push_back(add_at(32'h0005_E000, 32'hFFFF_FFF9, 32'h0000_0002));
		queued_cmds.push_back(read_at(CMD_READ, 16'd5));
		queued_cmds.push_back(read_at(CMD_READ, 16'd0));
		queued_cmds.push_back(read_at(CMD_READ, 16'd255));
		queued_cmds.push_back(read_at(CMD_READ_CLEAR, 16'd0));
		queued_cmds.push_back(read_at(CMD_READ, 16'd0));
		queued_cmds.push_back(read_at(CMD_READ, 16'hFFFF));
		queued_cmds.push_back(read_at(CMD_NONE, 16'($urandom)));
		run_random(40, 0, 0);

		set_config(4, 4, 3, 5, 2, 1, 3);
		run_random(80, 6, 1);

		// lin overflows past the memory once dimension one is nonzero
		set_config(2, 65536, 2, 65536, 65536, 0, 65536);
		run_random(60, 3, 2);

		// zero dims acts as one, window edges
		set_config(0, 16, 0, 1, 1, 5, 12);
		queued_cmds.push_back(add_at(32'h0004_FFFF, 32'h0000_0100, 32'h0000_0010));
		queued_cmds.push_back(add_at(32'h0005_0000, 32'h0000_0100, 32'h0000_0010));
		queued_cmds.push_back(add_at(32'h000B_FFFF, 32'h0000_0100, 32'h0000_0010));
		queued_cmds.push_back(add_at(32'h000C_0000, 32'h0000_0100, 32'h0000_0010));
		queued_cmds.push_back(add_at(32'h0010_0000, 32'h0000_0100, 32'h0000_0010));
		run_random(40, 8, 1);

		// dims above the limit acts as four
		set_config(7, 2, 3, 2, 4, 0, 2);
		run_random(60, 2, 0);

		// zero bins along dimension one
		set_config(2, 8, 0, 1, 1, 0, 8);
		run_random(20, 4, 2);

		// empty window with low above high
		set_config(1, 1, 65536, 1, 1, 65536, 0);
		run_random(20, 1, 1);

		set_config(3, 6, 5, 7, 1, 2, 5);
		run_random(80, 5, 2);

		// large sums of both signs on two bins, then read back and clear
		set_config(1, 2, 1, 1, 1, 0, 2);
		gap_max    = 0;
		ready_mode = 0;
		repeat (4) queued_cmds.push_back(add_at(32'h0000_8000, 32'h7FFF_FFFF,
			32'hFFFF_FFFF));
		repeat (4) queued_cmds.push_back(add_at(32'h0001_4000, 32'h8000_0000,
			32'h0000_0000));
		queued_cmds.push_back(read_at(CMD_READ, 16'd0));
		queued_cmds.push_back(read_at(CMD_READ_CLEAR, 16'd1));
		queued_cmds.push_back(read_at(CMD_READ, 16'd1));
		wait_idle();

		if (bad_outcomes == 0 && pending_outcomes.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/mhb_pkg.sv
rtl/multidim_histogram_binner_top.sv
tb/multidim_histogram_binner_top_tb.sv
